// ===== hw/rtl/joy_ar_pkg.sv =====
// ----------------------------------------------------------------------------
// joy_ar_pkg: shared types and codes for the joystick autorepeat block
// Payload structs, configuration set, machine states and register indexes.
// ----------------------------------------------------------------------------
package joy_ar_pkg;

  localparam int CFG_DATA_W = 16;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PUSH   = 1'b1;
  localparam logic KIND_AXIS = 1'b0;
  localparam logic KIND_HAT  = 1'b1;

  typedef enum logic [1:0] {
    REG_TICK_PERIOD   = 2'd0,
    REG_HOLD_TIME     = 2'd1,
    REG_REPEAT_PERIOD = 2'd2,
    REG_DEAD_ZONE     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_TEST   = 2'd0,
    MODE_HOLD   = 2'd1,
    MODE_REPEAT = 2'd2
  } mode_t;

  typedef struct packed {
    logic               operation;
    logic               event_kind;
    logic [15:0]        device_id;
    logic [5:0]         axis_index;
    logic signed [15:0] axis_value;
    logic [3:0]         hat_value;
  } in_t;

  typedef struct packed {
    logic               repeat_valid;
    logic               repeat_kind;
    logic [15:0]        repeat_device;
    logic [5:0]         repeat_axis;
    logic signed [15:0] repeat_axis_value;
    logic [3:0]         repeat_hat;
    logic               dropped;
  } out_t;

  // Normalized joystick event as kept in the event FIFO and the hold latch
  typedef struct packed {
    logic               kind;
    logic [15:0]        device;
    logic [5:0]         axis;
    logic signed [15:0] value;
    logic [3:0]         hat;
  } evt_t;

  typedef struct packed {
    logic is_push;
    evt_t evt;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  tick_period;
    logic [14:0] hold_time;
    logic [14:0] repeat_period;
    logic [14:0] dead_zone;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    logic  fifo_empty;
    logic  fifo_full;
  } stat_t;

endpackage

// ===== hw/rtl/joystick_autorepeat_fsm_top.sv =====
// ----------------------------------------------------------------------------
// joystick_autorepeat_fsm_top: typematic autorepeat for joystick events
// Queues axis/hat events and repeats a held one on time ticks.
//
//   channel | ports                           | direction | word
//   in      | in_valid, in_ready, in_data     | input     | tick or event push
//   out     | out_valid, out_ready, out_data  | output    | one result per input
//   cfg     | cfg_valid, cfg_ready, cfg_index,| input     | register write
//           | cfg_data                        |           |
//
// One word per cycle while the output is not stalled; a result is registered
// through the decode queue, then the result register.
// The event FIFO is a RAM with registered read; its front is read ahead from
// the next head address, with a bypass for a word written into the head slot.
// Reset is synchronous; no clearing pass, the FIFO fill count guards the RAM.
// A stalled output holds the back end; the two-entry queue fills, then
// in_ready falls.
// ----------------------------------------------------------------------------
module joystick_autorepeat_fsm_top #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  joy_ar_pkg::in_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output joy_ar_pkg::out_t                  out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [joy_ar_pkg::CFG_DATA_W-1:0] cfg_data
);

  joy_ar_pkg::cfg_t  cfg_r;
  joy_ar_pkg::cmd_t  dec_cmd, q_cmd;
  joy_ar_pkg::stat_t stat;
  logic              dec_valid, dec_ready, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period   <= 10'd10;
      cfg_r.hold_time     <= 15'd500;
      cfg_r.repeat_period <= 15'd100;
      cfg_r.dead_zone     <= 15'd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        joy_ar_pkg::REG_TICK_PERIOD:   cfg_r.tick_period   <= cfg_data[9:0];
        joy_ar_pkg::REG_HOLD_TIME:     cfg_r.hold_time     <= cfg_data[14:0];
        joy_ar_pkg::REG_REPEAT_PERIOD: cfg_r.repeat_period <= cfg_data[14:0];
        joy_ar_pkg::REG_DEAD_ZONE:     cfg_r.dead_zone     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  joy_ar_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (dec_valid),
    .cmd_ready (dec_ready),
    .cmd       (dec_cmd)
  );

  joy_ar_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (dec_valid),
    .wr_ready (dec_ready),
    .wr_cmd   (dec_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  joy_ar_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (stat)
  );

  a_fifo_levels: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.fifo_full && stat.fifo_empty))
    else $error("event FIFO reports full and empty at once");

  a_repeat_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.repeat_valid) |-> (stat.mode == joy_ar_pkg::MODE_REPEAT))
    else $error("repeat word issued outside repeat mode");

  a_repeat_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.repeat_valid) |-> !out_data.dropped)
    else $error("word flags both repeat and drop");

endmodule

// ===== hw/rtl/joy_ar_ram.sv =====
// ----------------------------------------------------------------------------
// joy_ar_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module joy_ar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/joy_ar_front.sv =====
// ----------------------------------------------------------------------------
// joy_ar_front: input decode
// Splits items into ticks and pushes and zeroes the unused event parts.
// ----------------------------------------------------------------------------
module joy_ar_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  joy_ar_pkg::in_t  in_data,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output joy_ar_pkg::cmd_t cmd
);

  always_comb begin
    cmd             = '0;
    cmd.is_push     = (in_data.operation == joy_ar_pkg::OP_PUSH);
    cmd.evt.kind    = in_data.event_kind;
    cmd.evt.device  = in_data.device_id;
    // keep only the part that belongs to this kind of event
    if (in_data.event_kind == joy_ar_pkg::KIND_AXIS) begin
      cmd.evt.axis  = in_data.axis_index;
      cmd.evt.value = in_data.axis_value;
    end else begin
      cmd.evt.hat   = in_data.hat_value;
    end
  end

  assign cmd_valid = in_valid;
  assign in_ready  = cmd_ready;

endmodule

// ===== hw/rtl/joy_ar_queue.sv =====
// ----------------------------------------------------------------------------
// joy_ar_queue: two-entry command queue
// Decouples decode from execution; ready comes straight from a register.
// ----------------------------------------------------------------------------
module joy_ar_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  joy_ar_pkg::cmd_t wr_cmd,
  output logic             rd_valid,
  input  logic             rd_ready,
  output joy_ar_pkg::cmd_t rd_cmd
);

  joy_ar_pkg::cmd_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ===== hw/rtl/joy_ar_back.sv =====
// ----------------------------------------------------------------------------
// joy_ar_back: event FIFO, test/hold/repeat machine and result register
// Executes one command per cycle while the result register can take it.
// ----------------------------------------------------------------------------
module joy_ar_back #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  joy_ar_pkg::cfg_t  cfg,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  joy_ar_pkg::cmd_t  cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output joy_ar_pkg::out_t  out_data,
  output joy_ar_pkg::stat_t stat
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int EW = $bits(joy_ar_pkg::evt_t);

  function automatic logic [16:0] mag17(input logic signed [15:0] v);
    logic signed [16:0] w;
    w = {v[15], v};
    mag17 = v[15] ? unsigned'(-w) : unsigned'(w);
  endfunction

  logic [AW-1:0]       head_r, head_nxt, head_inc, tail;
  logic [SW-1:0]       tail_sum;
  logic [CW-1:0]       count_r, count_nxt;
  joy_ar_pkg::mode_t   mode_r, mode_nxt;
  joy_ar_pkg::evt_t    held_r, held_nxt;
  logic [15:0]         elapsed_r, elapsed_nxt, grown, shrunk;
  logic [16:0]         grow_sum;
  logic                out_valid_r;
  joy_ar_pkg::out_t    out_data_r, result;
  logic                byp_r;
  joy_ar_pkg::evt_t    byp_data_r;
  logic [EW-1:0]       ram_rd;
  joy_ar_pkg::evt_t    front;
  logic                go, tick, push;
  logic                fifo_full, front_present, front_active, differs, reach;
  logic                wr_en, pop, emit, drop;
  logic [16:0]         dz17, front_mag, held_mag;

  assign go        = cmd_valid && (!out_valid_r || out_ready);
  assign cmd_ready = !out_valid_r || out_ready;
  assign push      = go && cmd.is_push;
  assign tick      = go && !cmd.is_push;

  // FIFO addressing, head + count wraps at most once
  assign tail_sum  = SW'(head_r) + SW'(count_r);
  assign tail      = (tail_sum >= SW'(FIFO_DEPTH)) ? AW'(tail_sum - SW'(FIFO_DEPTH))
                                                   : AW'(tail_sum);
  assign head_inc  = (head_r == AW'(FIFO_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign fifo_full = (count_r == CW'(FIFO_DEPTH));
  assign front_present = (count_r != '0);

  // front word: RAM read of the next head, or the word written there last cycle
  assign front = byp_r ? byp_data_r : joy_ar_pkg::evt_t'(ram_rd);

  assign dz17      = {2'b00, cfg.dead_zone};
  assign front_mag = mag17(front.value);
  assign held_mag  = mag17(held_r.value);

  assign front_active = (front.kind == joy_ar_pkg::KIND_HAT) ? (front.hat != 4'd0)
                                                             : (front_mag >= dz17);

  always_comb begin
    if (held_r.kind != front.kind) begin
      differs = 1'b1;
    end else if (front.kind == joy_ar_pkg::KIND_HAT) begin
      differs = (held_r.hat != front.hat);
    end else begin
      differs = (held_r.axis != front.axis) || (held_r.value[15] != front.value[15]) ||
                ((held_mag < dz17) != (front_mag < dz17));
    end
  end

  // elapsed time: saturating grow, then clamped subtract of the repeat period
  assign grow_sum = {1'b0, elapsed_r} + {7'd0, cfg.tick_period};
  assign grown    = grow_sum[16] ? 16'hFFFF : grow_sum[15:0];
  assign reach    = (grown >= {1'b0, cfg.hold_time});
  assign shrunk   = (grown > {1'b0, cfg.repeat_period}) ? grown - {1'b0, cfg.repeat_period}
                                                        : 16'd0;

  // next state
  always_comb begin
    mode_nxt = mode_r;
    if (tick) begin
      case (mode_r)
        joy_ar_pkg::MODE_HOLD, joy_ar_pkg::MODE_REPEAT: begin
          if (front_present && differs) begin
            mode_nxt = joy_ar_pkg::MODE_TEST;
          end else if (mode_r == joy_ar_pkg::MODE_HOLD && reach) begin
            mode_nxt = joy_ar_pkg::MODE_REPEAT;
          end
        end
        default: begin
          mode_nxt = (front_present && front_active) ? joy_ar_pkg::MODE_HOLD
                                                     : joy_ar_pkg::MODE_TEST;
        end
      endcase
    end
  end

  // actions
  always_comb begin
    pop         = 1'b0;
    emit        = 1'b0;
    held_nxt    = held_r;
    elapsed_nxt = elapsed_r;
    wr_en       = push && !fifo_full;
    drop        = push && fifo_full;
    if (tick) begin
      case (mode_r)
        joy_ar_pkg::MODE_HOLD, joy_ar_pkg::MODE_REPEAT: begin
          elapsed_nxt = grown;
          pop         = front_present && !differs;
          if (!(front_present && differs) && mode_r == joy_ar_pkg::MODE_REPEAT && reach) begin
            emit        = 1'b1;
            elapsed_nxt = shrunk;
          end
        end
        default: begin
          pop = front_present;
          if (front_present && front_active) begin
            held_nxt    = front;
            elapsed_nxt = 16'd0;
          end
        end
      endcase
    end
  end

  always_comb begin
    head_nxt  = pop ? head_inc : head_r;
    count_nxt = count_r + CW'(wr_en) - CW'(pop);
  end

  always_comb begin
    result         = '0;
    result.dropped = drop;
    if (emit) begin
      result.repeat_valid      = 1'b1;
      result.repeat_kind       = held_r.kind;
      result.repeat_device     = held_r.device;
      result.repeat_axis       = held_r.axis;
      result.repeat_axis_value = held_r.value;
      result.repeat_hat        = held_r.hat;
    end
  end

  joy_ar_ram #(
    .WIDTH (EW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (cmd.evt),
    .rd_addr (head_nxt),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      mode_r      <= joy_ar_pkg::MODE_TEST;
      held_r      <= '0;
      elapsed_r   <= 16'd0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      mode_r    <= mode_nxt;
      held_r    <= held_nxt;
      elapsed_r <= elapsed_nxt;
      byp_r     <= wr_en && (tail == head_nxt);
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= cmd.evt;
    if (go) begin
      out_data_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.mode       = mode_r;
  assign stat.fifo_empty = !front_present;
  assign stat.fifo_full  = fifo_full;

endmodule

// ===== tb/tb_joystick_autorepeat_fsm_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_autorepeat_fsm_top: self-checking bench for joystick autorepeat
// A table of directed words runs first, followed by phases of random tick and
// push traffic under changing register settings. The phases use hold
// sequences, push bursts and noise. The table or an in-bench model gives every
// result, and a monitor checks each output word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_joystick_autorepeat_fsm_top;

  localparam int FIFO_DEPTH      = 16;
  localparam int DIR_ROWS        = 25;
  localparam int NUM_PHASES      = 8;
  localparam int PHASE_WORDS     = 25;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER  = 130;
  localparam int CYCLE_LIMIT     = 300000;

  typedef struct packed {
    joy_ar_pkg::in_t  word;
    logic             chk;
    joy_ar_pkg::out_t res;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  joy_ar_pkg::in_t  in_data;
  logic             out_valid;
  logic             out_ready;
  joy_ar_pkg::out_t out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_data;

  // model of the block
  joy_ar_pkg::cfg_t  pred_cfg    = '{10'd10, 15'd500, 15'd100, 15'd4096};
  joy_ar_pkg::mode_t ar_mode     = joy_ar_pkg::MODE_TEST;
  joy_ar_pkg::evt_t  held_ev     = '0;
  int unsigned       ar_elapsed  = 0;
  joy_ar_pkg::evt_t  ev_fifo[$];

  joy_ar_pkg::out_t  ar_results_q[$];
  joy_ar_pkg::out_t  mon_want;
  dir_row_t          dir_tab [DIR_ROWS];

  int n_acc      = 0;
  int n_checked  = 0;
  int n_repeats  = 0;
  int n_drops    = 0;
  int n_mism     = 0;
  int n_settings = 0;
  int n_cyc      = 0;
  bit idle_on    = 1'b1;
  bit held_off   = 1'b0;

  joystick_autorepeat_fsm_top #(.FIFO_DEPTH(FIFO_DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
  end

  // ---------------------------------------------------------------- model
  function automatic int mag(logic signed [15:0] v);
    int s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  function automatic bit ev_active(joy_ar_pkg::evt_t e);
    int dz;
    dz = pred_cfg.dead_zone;
    if (e.kind == joy_ar_pkg::KIND_AXIS) return mag(e.value) >= dz;
    return e.hat != 4'd0;
  endfunction

  // device id is left out of the comparison
  function automatic bit ev_differs(joy_ar_pkg::evt_t a, joy_ar_pkg::evt_t b);
    int dz;
    dz = pred_cfg.dead_zone;
    if (a.kind != b.kind) return 1'b1;
    if (b.kind == joy_ar_pkg::KIND_HAT) return a.hat != b.hat;
    if (a.axis != b.axis) return 1'b1;
    if (a.value[15] != b.value[15]) return 1'b1;
    return (mag(a.value) < dz) != (mag(b.value) < dz);
  endfunction

  function automatic joy_ar_pkg::out_t autorepeat_step(joy_ar_pkg::in_t w);
    joy_ar_pkg::out_t r;
    joy_ar_pkg::evt_t e;
    bit               back;
    int unsigned      t;
    r = '0;
    if (w.operation == joy_ar_pkg::OP_PUSH) begin
      e        = '0;
      e.kind   = w.event_kind;
      e.device = w.device_id;
      if (w.event_kind == joy_ar_pkg::KIND_AXIS) begin
        e.axis  = w.axis_index;
        e.value = w.axis_value;
      end else begin
        e.hat = w.hat_value;
      end
      if (ev_fifo.size() >= FIFO_DEPTH) r.dropped = 1'b1;
      else ev_fifo.insert(ev_fifo.size(), e);
    end else if (ar_mode == joy_ar_pkg::MODE_TEST) begin
      if (ev_fifo.size() > 0) begin
        if (ev_active(ev_fifo[0])) begin
          held_ev    = ev_fifo[0];
          ar_elapsed = 0;
          ar_mode    = joy_ar_pkg::MODE_HOLD;
        end
        ev_fifo.delete(0);
      end
    end else begin
      t          = ar_elapsed + pred_cfg.tick_period;
      ar_elapsed = (t > 65535) ? 65535 : t;
      back       = 1'b0;
      if (ev_fifo.size() > 0) begin
        if (ev_differs(held_ev, ev_fifo[0])) back = 1'b1;
        else ev_fifo.delete(0);
      end
      if (back) begin
        ar_mode = joy_ar_pkg::MODE_TEST;
      end else if (ar_mode == joy_ar_pkg::MODE_HOLD) begin
        if (ar_elapsed >= pred_cfg.hold_time) ar_mode = joy_ar_pkg::MODE_REPEAT;
      end else if (ar_elapsed >= pred_cfg.hold_time) begin
        r.repeat_valid      = 1'b1;
        r.repeat_kind       = held_ev.kind;
        r.repeat_device     = held_ev.device;
        r.repeat_axis       = held_ev.axis;
        r.repeat_axis_value = held_ev.value;
        r.repeat_hat        = held_ev.hat;
        ar_elapsed = (ar_elapsed > pred_cfg.repeat_period) ?
                     ar_elapsed - pred_cfg.repeat_period : 0;
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus
  function automatic joy_ar_pkg::in_t rand_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(joy_ar_pkg::in_t)-1:0];
  endfunction

  function automatic joy_ar_pkg::in_t mk_tick();
    joy_ar_pkg::in_t w;
    w = rand_word();
    w.operation = joy_ar_pkg::OP_TICK;
    return w;
  endfunction

  // hat field carries junk to check that axis events drop it
  function automatic joy_ar_pkg::in_t mk_axis(logic [15:0] dev, logic [5:0] idx,
                                              logic [15:0] val);
    joy_ar_pkg::in_t w;
    w = '{joy_ar_pkg::OP_PUSH, joy_ar_pkg::KIND_AXIS, dev, idx, val, 4'hA};
    return w;
  endfunction

  function automatic joy_ar_pkg::in_t mk_hat(logic [15:0] dev, logic [5:0] idx,
                                             logic [15:0] val, logic [3:0] hat);
    joy_ar_pkg::in_t w;
    w = '{joy_ar_pkg::OP_PUSH, joy_ar_pkg::KIND_HAT, dev, idx, val, hat};
    return w;
  endfunction

  // axis value at or above the dead zone with the given sign
  function automatic logic [15:0] active_value(logic neg);
    int lo;
    int m;
    lo = pred_cfg.dead_zone;
    if (neg) begin
      if (lo < 1) lo = 1;
      m = $urandom_range(32768, lo);
      return 16'(-m);
    end
    m = $urandom_range(32767, lo);
    return 16'(m);
  endfunction

  function automatic joy_ar_pkg::in_t rand_active();
    joy_ar_pkg::in_t w;
    w = rand_word();
    w.operation = joy_ar_pkg::OP_PUSH;
    if (w.event_kind == joy_ar_pkg::KIND_AXIS) w.axis_value = active_value(w.axis_value[15]);
    else w.hat_value = 4'($urandom_range(15, 1));
    return w;
  endfunction

  // same class as the held word, fresh device and magnitude
  function automatic joy_ar_pkg::in_t like_held(joy_ar_pkg::in_t base);
    joy_ar_pkg::in_t w;
    w = rand_word();
    w.operation  = joy_ar_pkg::OP_PUSH;
    w.event_kind = base.event_kind;
    if (base.event_kind == joy_ar_pkg::KIND_AXIS) begin
      w.axis_index = base.axis_index;
      w.axis_value = active_value(base.axis_value[15]);
    end else begin
      w.hat_value = base.hat_value;
    end
    return w;
  endfunction

  function automatic joy_ar_pkg::in_t rand_centred();
    joy_ar_pkg::in_t w;
    int              dz;
    w  = rand_word();
    dz = pred_cfg.dead_zone;
    w.operation = joy_ar_pkg::OP_PUSH;
    if (w.event_kind == joy_ar_pkg::KIND_AXIS && dz > 0) begin
      w.axis_value = 16'($urandom_range(dz - 1, 0));
      if ($urandom_range(0, 1) == 1) w.axis_value = -w.axis_value;
    end else begin
      w.event_kind = joy_ar_pkg::KIND_HAT;
      w.hat_value  = 4'd0;
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // hold valid until taken; return on the falling edge that follows, valid still high
  task automatic send_word(joy_ar_pkg::in_t w, logic chk, joy_ar_pkg::out_t res);
    int               gap;
    joy_ar_pkg::out_t pred;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    pred = autorepeat_step(w);
    ar_results_q.insert(ar_results_q.size(), chk ? res : pred);
    n_acc++;
    @(negedge clk);
  endtask

  task automatic push_word(joy_ar_pkg::in_t w);
    send_word(w, 1'b0, '0);
  endtask

  task automatic cfg_write(joy_ar_pkg::reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      joy_ar_pkg::REG_TICK_PERIOD:   pred_cfg.tick_period   = val[9:0];
      joy_ar_pkg::REG_HOLD_TIME:     pred_cfg.hold_time     = val[14:0];
      joy_ar_pkg::REG_REPEAT_PERIOD: pred_cfg.repeat_period = val[14:0];
      joy_ar_pkg::REG_DEAD_ZONE:     pred_cfg.dead_zone     = val[14:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_cfg(logic [15:0] tick, logic [15:0] hold, logic [15:0] rep,
                          logic [15:0] dz);
    cfg_write(joy_ar_pkg::REG_TICK_PERIOD, tick);
    cfg_write(joy_ar_pkg::REG_HOLD_TIME, hold);
    cfg_write(joy_ar_pkg::REG_REPEAT_PERIOD, rep);
    cfg_write(joy_ar_pkg::REG_DEAD_ZONE, dz);
    cfg_valid <= 1'b0;
    n_settings++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ar_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // latch an active word, tick it toward hold and repeat, then maybe break it
  task automatic hold_sequence();
    joy_ar_pkg::in_t held_w;
    int              n;
    held_w = rand_active();
    push_word(held_w);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 60) : $urandom_range(40, 1);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) push_word(like_held(held_w));
      push_word(mk_tick());
    end
    case ($urandom_range(0, 2))
      0: push_word(rand_centred());
      1: push_word(rand_word());
      default: ;
    endcase
  endtask

  task automatic phase_config(int ph);
    int t;
    int h;
    case (ph)
      0: load_cfg(16'd1023, 16'd32767, 16'd0, 16'd0);
      1: load_cfg(16'd0, 16'd0, 16'd32767, 16'd32767);
      2: load_cfg(16'd10, 16'd500, 16'd100, 16'd4096);
      3: load_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      default: begin
        t = $urandom_range(1000, 1);
        h = $urandom_range((t * 20 > 30000) ? 30000 : t * 20, 1);
        load_cfg(16'(t), 16'(h), 16'($urandom_range(30000, 1)),
                 16'($urandom_range(32767, 0)));
      end
    endcase
  endtask

  // ------------------------------------------------------------- checking
  task automatic check_result(joy_ar_pkg::out_t want, joy_ar_pkg::out_t got);
    if (got.repeat_valid      !== want.repeat_valid      ||
        got.repeat_kind       !== want.repeat_kind       ||
        got.repeat_device     !== want.repeat_device     ||
        got.repeat_axis       !== want.repeat_axis       ||
        got.repeat_axis_value !== want.repeat_axis_value ||
        got.repeat_hat        !== want.repeat_hat        ||
        got.dropped           !== want.dropped) begin
      if (n_mism < 10) begin
        $display("Mismatch at result %0d: want v%0b k%0b dev %h ax %0d val %0d hat %h drop %0b",
                 n_checked, want.repeat_valid, want.repeat_kind, want.repeat_device,
                 want.repeat_axis, want.repeat_axis_value, want.repeat_hat, want.dropped);
        $display("                      got  v%0b k%0b dev %h ax %0d val %0d hat %h drop %0b",
                 got.repeat_valid, got.repeat_kind, got.repeat_device,
                 got.repeat_axis, got.repeat_axis_value, got.repeat_hat, got.dropped);
      end
      n_mism++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (ar_results_q.size() == 0) begin
        if (n_mism < 10) $display("Unexpected result word with nothing pending");
        n_mism++;
      end else begin
        mon_want = ar_results_q[0];
        ar_results_q.delete(0);
        check_result(mon_want, out_data);
        if (out_data.repeat_valid === 1'b1) n_repeats++;
        if (out_data.dropped === 1'b1) n_drops++;
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    n_cyc++;
    if (n_cyc >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", n_cyc, ar_results_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the input
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (!held_off && n_acc >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 9) < 7) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(24, 1)) @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
        repeat (n) @(negedge clk);
      end
    end
  end

  // ----------------------------------------------------------------- main
  initial begin
    int ph;
    int start;
    int pick;
    dir_tab = '{
      '{mk_tick(),                                         1'b1, '0}, // empty queue
      '{mk_axis(16'hFFFF, 6'd63, 16'h8000),                1'b1, '0}, // most negative
      '{mk_tick(),                                         1'b1, '0}, // latch
      '{mk_axis(16'h0000, 6'd63, 16'hF000),                1'b1, '0}, // same, other device
      '{mk_tick(),                                         1'b0, '0},
      '{mk_tick(),                                         1'b0, '0}, // enter repeat
      '{mk_tick(),                                         1'b0, '0}, // first repeat
      '{mk_axis(16'h0001, 6'd63, 16'h7FFF),                1'b1, '0}, // sign flips
      '{mk_tick(),                                         1'b0, '0}, // back to test
      '{mk_tick(),                                         1'b1, '0},
      '{mk_axis(16'h0002, 6'd62, 16'h7FFF),                1'b1, '0}, // other axis
      '{mk_tick(),                                         1'b0, '0},
      '{mk_tick(),                                         1'b1, '0},
      '{mk_axis(16'h0003, 6'd62, 16'h0FFF),                1'b1, '0}, // just inside dead zone
      '{mk_tick(),                                         1'b0, '0},
      '{mk_tick(),                                         1'b1, '0}, // drop centred front
      '{mk_hat(16'h1234, 6'h15, 16'h5555, 4'hF),           1'b1, '0}, // hat with junk axis
      '{mk_tick(),                                         1'b1, '0},
      '{mk_tick(),                                         1'b0, '0},
      '{mk_tick(),                                         1'b0, '0},
      '{mk_tick(),                                         1'b0, '0}, // hat repeat, zero axis
      '{mk_hat(16'h4321, 6'h2A, 16'hAAAA, 4'h0),           1'b1, '0}, // hat centred
      '{mk_tick(),                                         1'b0, '0},
      '{mk_tick(),                                         1'b1, '0},
      '{mk_tick(),                                         1'b1, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_cfg(16'd100, 16'd200, 16'd100, 16'd4096);
    for (int i = 0; i < DIR_ROWS; i++) send_word(dir_tab[i].word, dir_tab[i].chk, dir_tab[i].res);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      phase_config(ph);
      idle_on = ($urandom_range(0, 4) != 0);
      start   = n_acc;
      while (n_acc - start < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          hold_sequence();
        end else if (pick < 80) begin
          // burst of active pushes that can overfill the event queue
          repeat ($urandom_range(20, 10)) push_word(rand_active());
        end else begin
          repeat ($urandom_range(8, 1)) push_word(rand_word());
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d results from %0d words across %0d register settings",
             n_checked, n_acc, n_settings);
    $display("Seen %0d repeats and %0d dropped pushes, %0d mismatches",
             n_repeats, n_drops, n_mism);
    if (n_mism == 0 && ar_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
